>>> hw/rtl/lswc_pkg.sv
// Shared types and constants of the line segment window clipper.
`timescale 1ns / 1ps
package lswc_pkg;

  localparam int COORD_BITS_DEF = 16;

  // Configuration register indexes.
  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_RIGHT  = 2'd1;
  localparam logic [1:0] REG_BOTTOM = 2'd2;
  localparam logic [1:0] REG_TOP    = 2'd3;

  // Window reset values.
  localparam int RST_LEFT   = 0;
  localparam int RST_RIGHT  = 10239;
  localparam int RST_BOTTOM = 0;
  localparam int RST_TOP    = 7679;

  typedef enum logic [2:0] {
    CODE_NONE    = 3'd0,
    CODE_START   = 3'd1,
    CODE_END     = 3'd2,
    CODE_BOTH    = 3'd3,
    CODE_OUTSIDE = 3'd4
  } clip_code_e;

  typedef struct packed {
    logic       outside;
    logic [2:0] code;
  } clip_ctrl_t;

endpackage

>>> hw/rtl/line_segment_window_clip_core.sv
// Top level of the line segment window clipper: window registers and four clip steps.
// Throughput: one segment per cycle; each step holds a pipelined divider of one
// quotient bit per stage, so a new segment can enter before earlier ones are done.
// busy_o stays low and the receiver cannot stall; done_o pulses for one cycle.
// Reset clears all valid bits and loads the window with its reset values.
`timescale 1ns / 1ps
module line_segment_window_clip_core #(
  parameter int COORD_BITS = lswc_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [COORD_BITS-1:0]        cfg_wdata_i,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  output logic                         done_o,
  output logic signed [COORD_BITS-1:0] clipped_start_x_o,
  output logic signed [COORD_BITS-1:0] clipped_start_y_o,
  output logic signed [COORD_BITS-1:0] clipped_end_x_o,
  output logic signed [COORD_BITS-1:0] clipped_end_y_o,
  output logic [2:0]                   clip_code_o
);

  localparam int C   = COORD_BITS;
  localparam int LAT = 4 * (2 * (C + 1) + 4) + 1;

  logic signed [C-1:0] left_q, right_q, bottom_q, top_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= C'(lswc_pkg::RST_LEFT);
      right_q  <= C'(lswc_pkg::RST_RIGHT);
      bottom_q <= C'(lswc_pkg::RST_BOTTOM);
      top_q    <= C'(lswc_pkg::RST_TOP);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lswc_pkg::REG_LEFT:   left_q   <= cfg_wdata_i;
        lswc_pkg::REG_RIGHT:  right_q  <= cfg_wdata_i;
        lswc_pkg::REG_BOTTOM: bottom_q <= cfg_wdata_i;
        lswc_pkg::REG_TOP:    top_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  logic                 v [5];
  lswc_pkg::clip_ctrl_t c [5];
  logic signed [C-1:0]  x1 [5];
  logic signed [C-1:0]  y1 [5];
  logic signed [C-1:0]  x2 [5];
  logic signed [C-1:0]  y2 [5];

  assign v[0]  = start_i;
  assign c[0]  = '{outside: 1'b0, code: lswc_pkg::CODE_NONE};
  assign x1[0] = start_x_i;
  assign y1[0] = start_y_i;
  assign x2[0] = end_x_i;
  assign y2[0] = end_y_i;

  // Steps in order: start x, end x, start y, end y.
  for (genvar s = 0; s < 4; s++) begin : g_step
    lswc_step #(
      .C     (C),
      .IS_Y  (s >= 2),
      .IS_END(s % 2 == 1)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v[s]),
      .ctrl_i  (c[s]),
      .x1_i    (x1[s]),
      .y1_i    (y1[s]),
      .x2_i    (x2[s]),
      .y2_i    (y2[s]),
      .win_lo_i((s >= 2) ? bottom_q : left_q),
      .win_hi_i((s >= 2) ? top_q : right_q),
      .valid_o (v[s+1]),
      .ctrl_o  (c[s+1]),
      .x1_o    (x1[s+1]),
      .y1_o    (y1[s+1]),
      .x2_o    (x2[s+1]),
      .y2_o    (y2[s+1])
    );
  end

  logic                done_q;
  logic signed [C-1:0] sx_q, sy_q, ex_q, ey_q;
  logic [2:0]          code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v[4];
    end
  end

  always_ff @(posedge clk_i) begin
    if (c[4].outside) begin
      sx_q   <= '0;
      sy_q   <= '0;
      ex_q   <= '0;
      ey_q   <= '0;
      code_q <= lswc_pkg::CODE_OUTSIDE;
    end else begin
      sx_q   <= x1[4];
      sy_q   <= y1[4];
      ex_q   <= x2[4];
      ey_q   <= y2[4];
      code_q <= c[4].code;
    end
  end

  assign done_o            = done_q;
  assign clipped_start_x_o = sx_q;
  assign clipped_start_y_o = sy_q;
  assign clipped_end_x_o   = ex_q;
  assign clipped_end_y_o   = ey_q;
  assign clip_code_o       = code_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##LAT done_o)
    else $error("segment did not complete after the pipeline latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LAT))
    else $error("word delivered without a matching start");

  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && clip_code_o == lswc_pkg::CODE_OUTSIDE) |->
      (clipped_start_x_o == '0 && clipped_start_y_o == '0 &&
       clipped_end_x_o == '0 && clipped_end_y_o == '0))
    else $error("outside segment carries nonzero coordinates");

endmodule

>>> hw/rtl/lswc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side payload.
`timescale 1ns / 1ps
module lswc_div #(
  parameter int NW   = 34,
  parameter int DW   = 17,
  parameter int PAYW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [NW-1:0]   num_i,
  input  logic [DW-1:0]   den_i,
  input  logic [PAYW-1:0] pay_i,
  output logic            valid_o,
  output logic [NW-1:0]   quo_o,
  output logic [PAYW-1:0] pay_o
);

  logic [NW-1:0]   valid_q;
  logic [DW-1:0]   rem_q [NW];
  logic [NW-1:0]   num_q [NW];
  logic [NW-1:0]   quo_q [NW];
  logic [DW-1:0]   den_q [NW];
  logic [PAYW-1:0] pay_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic            v_p;
    logic [DW-1:0]   rem_p;
    logic [NW-1:0]   num_p;
    logic [NW-1:0]   quo_p;
    logic [DW-1:0]   den_p;
    logic [PAYW-1:0] pay_p;
    logic [DW:0]     trial;
    logic            ge;
    logic [DW:0]     diff;

    if (k == 0) begin : g_first
      assign v_p   = valid_i;
      assign rem_p = '0;
      assign num_p = num_i;
      assign quo_p = '0;
      assign den_p = den_i;
      assign pay_p = pay_i;
    end else begin : g_next
      assign v_p   = valid_q[k-1];
      assign rem_p = rem_q[k-1];
      assign num_p = num_q[k-1];
      assign quo_p = quo_q[k-1];
      assign den_p = den_q[k-1];
      assign pay_p = pay_q[k-1];
    end

    assign trial = {rem_p, num_p[NW-1]};
    assign ge    = trial >= {1'b0, den_p};
    assign diff  = trial - {1'b0, den_p};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
      num_q[k] <= {num_p[NW-2:0], 1'b0};
      quo_q[k] <= {quo_p[NW-2:0], ge};
      den_q[k] <= den_p;
      pay_q[k] <= pay_p;
    end
  end

  assign valid_o = valid_q[NW-1];
  assign quo_o   = quo_q[NW-1];
  assign pay_o   = pay_q[NW-1];

endmodule

>>> hw/rtl/lswc_step.sv
// One clipping step: one end point against one pair of window edges.
`timescale 1ns / 1ps
module lswc_step #(
  parameter int C      = 16,
  parameter bit IS_Y   = 1'b0,
  parameter bit IS_END = 1'b0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  lswc_pkg::clip_ctrl_t ctrl_i,
  input  logic signed [C-1:0] x1_i,
  input  logic signed [C-1:0] y1_i,
  input  logic signed [C-1:0] x2_i,
  input  logic signed [C-1:0] y2_i,
  input  logic signed [C-1:0] win_lo_i,
  input  logic signed [C-1:0] win_hi_i,
  output logic                valid_o,
  output lswc_pkg::clip_ctrl_t ctrl_o,
  output logic signed [C-1:0] x1_o,
  output logic signed [C-1:0] y1_o,
  output logic signed [C-1:0] x2_o,
  output logic signed [C-1:0] y2_o
);

  localparam int MW   = C + 1;
  localparam int PW   = 2 * MW;
  localparam int SW   = PW + 2;
  localparam int PAYW = $bits(lswc_pkg::clip_ctrl_t) + 5 * C + 3;

  // Decide stage.
  logic signed [C-1:0] ps, pe, os, oe, t, e;
  logic below, above, hit, out_now;
  lswc_pkg::clip_ctrl_t ctrl_d;

  assign ps = IS_Y ? y1_i : x1_i;
  assign pe = IS_Y ? y2_i : x2_i;
  assign os = IS_Y ? x1_i : y1_i;
  assign oe = IS_Y ? x2_i : y2_i;
  assign t  = IS_END ? pe : ps;
  assign below = t < win_lo_i;
  assign above = t > win_hi_i;
  assign e     = below ? win_lo_i : win_hi_i;
  // Only the start-point steps can find the whole segment past one edge.
  // The low edge is checked first, which matters for an inverted window.
  assign out_now = !IS_END && !ctrl_i.outside &&
                   (below ? (pe < win_lo_i) : (above && (pe > win_hi_i)));
  assign hit = (below || above) && !ctrl_i.outside && !out_now;

  always_comb begin
    ctrl_d = ctrl_i;
    ctrl_d.outside = ctrl_i.outside | out_now;
  end

  logic                 v0_q, v1_q, v2_q;
  lswc_pkg::clip_ctrl_t c0_q, c1_q, c2_q;
  logic signed [C-1:0]  x10_q, y10_q, x20_q, y20_q, e0_q;
  logic signed [C-1:0]  x11_q, y11_q, x21_q, y21_q, e1_q;
  logic signed [C-1:0]  x12_q, y12_q, x22_q, y22_q, e2_q;
  logic                 hit0_q, hit1_q, hit2_q;
  logic signed [C:0]    a_q, b_q, d_q;
  logic [MW-1:0]        ma_q, mb_q, md_q, md2_q;
  logic                 neg1_q, neg2_q, dz1_q, dz2_q;
  logic [PW-1:0]        prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // Differences: distance to the edge and the two extents.
    c0_q   <= ctrl_d;
    x10_q  <= x1_i;
    y10_q  <= y1_i;
    x20_q  <= x2_i;
    y20_q  <= y2_i;
    e0_q   <= e;
    hit0_q <= hit;
    a_q    <= {e[C-1], e} - {ps[C-1], ps};
    b_q    <= {oe[C-1], oe} - {os[C-1], os};
    d_q    <= {pe[C-1], pe} - {ps[C-1], ps};
    // Magnitudes and the sign of the quotient.
    c1_q   <= c0_q;
    x11_q  <= x10_q;
    y11_q  <= y10_q;
    x21_q  <= x20_q;
    y21_q  <= y20_q;
    e1_q   <= e0_q;
    hit1_q <= hit0_q;
    ma_q   <= a_q[C] ? MW'(~a_q + 1'b1) : MW'(a_q);
    mb_q   <= b_q[C] ? MW'(~b_q + 1'b1) : MW'(b_q);
    md_q   <= d_q[C] ? MW'(~d_q + 1'b1) : MW'(d_q);
    neg1_q <= a_q[C] ^ b_q[C] ^ d_q[C];
    dz1_q  <= d_q == '0;
    // Product.
    c2_q   <= c1_q;
    x12_q  <= x11_q;
    y12_q  <= y11_q;
    x22_q  <= x21_q;
    y22_q  <= y21_q;
    e2_q   <= e1_q;
    hit2_q <= hit1_q;
    prod_q <= PW'(ma_q) * PW'(mb_q);
    md2_q  <= md_q;
    neg2_q <= neg1_q;
    dz2_q  <= dz1_q;
  end

  logic                 dv;
  logic [PW-1:0]        quo;
  logic [PAYW-1:0]      pay_in, pay_out;
  lswc_pkg::clip_ctrl_t c3;
  logic signed [C-1:0]  x13, y13, x23, y23, e3;
  logic                 hit3, neg3, dz3;

  assign pay_in = {c2_q, x12_q, y12_q, x22_q, y22_q, e2_q, hit2_q, neg2_q, dz2_q};

  lswc_div #(
    .NW  (PW),
    .DW  (MW),
    .PAYW(PAYW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v2_q),
    .num_i  (prod_q),
    .den_i  (md2_q),
    .pay_i  (pay_in),
    .valid_o(dv),
    .quo_o  (quo),
    .pay_o  (pay_out)
  );

  assign {c3, x13, y13, x23, y23, e3, hit3, neg3, dz3} = pay_out;

  // Final stage: signed quotient plus base, saturated; the base alone when the extent d is zero.
  logic signed [C-1:0]  base, sat_v, new_o;
  logic signed [SW-1:0] sq, sum;
  logic                 fits;
  lswc_pkg::clip_ctrl_t c_d;
  logic signed [C-1:0]  x1_d, y1_d, x2_d, y2_d;

  assign base = IS_Y ? x13 : y13;
  assign sq   = neg3 ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
  assign sum  = SW'(base) + sq;
  assign fits = (sum[SW-1:C-1] == '0) || (sum[SW-1:C-1] == '1);

  always_comb begin
    if (fits) begin
      sat_v = sum[C-1:0];
    end else if (sum[SW-1]) begin
      sat_v = {1'b1, {(C-1){1'b0}}};
    end else begin
      sat_v = {1'b0, {(C-1){1'b1}}};
    end
    new_o = dz3 ? base : sat_v;
    c_d  = c3;
    x1_d = x13;
    y1_d = y13;
    x2_d = x23;
    y2_d = y23;
    if (hit3) begin
      c_d.code = c3.code | (IS_END ? lswc_pkg::CODE_END : lswc_pkg::CODE_START);
      if (IS_END) begin
        if (IS_Y) begin
          y2_d = e3;
          x2_d = new_o;
        end else begin
          x2_d = e3;
          y2_d = new_o;
        end
      end else begin
        if (IS_Y) begin
          y1_d = e3;
          x1_d = new_o;
        end else begin
          x1_d = e3;
          y1_d = new_o;
        end
      end
    end
  end

  logic                 v4_q;
  lswc_pkg::clip_ctrl_t c4_q;
  logic signed [C-1:0]  x14_q, y14_q, x24_q, y24_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    c4_q  <= c_d;
    x14_q <= x1_d;
    y14_q <= y1_d;
    x24_q <= x2_d;
    y24_q <= y2_d;
  end

  assign valid_o = v4_q;
  assign ctrl_o  = c4_q;
  assign x1_o    = x14_q;
  assign y1_o    = y14_q;
  assign x2_o    = x24_q;
  assign y2_o    = y24_q;

endmodule
